// ===== hdl/ssk_pkg.sv =====
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared codes and types for the severity-sorted keyed table.
// ----------------------------------------------------------------------------
package ssk_pkg;

    // Widths of the stream fields
    localparam int KEY_W   = 64;
    localparam int SEV_W   = 16;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // Request codes; any other code acts as a view
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VIEW   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // What every cell does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occ;    // cell lies below the fill count
    } t_cell_ctl;

endpackage

// ===== hdl/severity_sorted_keyed_table.sv =====
// ----------------------------------------------------------------------------
// severity_sorted_keyed_table
// Bounded table of (key, severity) entries kept in ascending severity order.
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells; cell 0 holds the lowest severity.
// An insert goes after all entries of equal severity and returns one result
// (status full, table unchanged, when CAPACITY entries are held). A remove
// deletes the first entry whose key matches and returns it, or status not
// found. For insert and remove, every cell decides from its own and its
// neighbors' contents whether to hold, load or shift. A view rotates the
// occupied cells toward cell 0 and sends one result per entry. The cycle
// that takes a view request loads nothing; then one entry leaves per cycle
// while the output register is free or being drained, and the input is
// held until the last has left (an empty table gives a single result with
// entry_valid low); the rotation leaves the table as it was. A new request
// is taken only when no view is running and the output register is free or
// being drained this cycle, so with a ready consumer inserts and removes run
// at one per cycle and a view, once started, at one entry per cycle.
// Only the low KEY_BITS of the key are stored and compared; the severity is
// sign-extended or wrapped to SEVERITY_BITS before it is stored.
// ----------------------------------------------------------------------------
module severity_sorted_keyed_table
    import ssk_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int KEY_BITS      = 64,
    parameter int SEVERITY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // key[63:0], severity[79:64]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // entry_key[63:0], entry_severity[79:64],
                                        // entry_count[84:80], zero[87:85]
    output logic [2:0]  m_axis_tuser,   // status[1:0], entry_valid[2]
    output logic        m_axis_tlast    // last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_VIEW = 1'b1;

    // Control state
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_m_valid;

    // Output register payload
    logic        [STAT_W-1:0]  r_status, n_status;
    logic                      r_ent_valid, n_ent_valid;
    logic        [KEY_W-1:0]   r_ent_key, n_ent_key;
    logic signed [SEV_W-1:0]   r_ent_sev, n_ent_sev;
    logic        [COUNT_W-1:0] r_ent_count;
    logic                      r_last, n_last;
    logic                      load_out;

    // Request fields
    logic        [REQ_W-1:0]         req;
    logic signed [SEV_W-1:0]         in_sev;
    logic        [KEY_BITS-1:0]      new_key;
    logic signed [SEVERITY_BITS-1:0] new_sev;

    // Cell row
    t_cell_op                        cell_op;
    t_cell_ctl                       cell_ctl  [CAPACITY];
    logic        [KEY_BITS-1:0]      cell_key  [CAPACITY];
    logic signed [SEVERITY_BITS-1:0] cell_sev  [CAPACITY];
    logic        [KEY_BITS-1:0]      left_key  [CAPACITY];
    logic signed [SEVERITY_BITS-1:0] left_sev  [CAPACITY];
    logic        [KEY_BITS-1:0]      right_key [CAPACITY];
    logic signed [SEVERITY_BITS-1:0] right_sev [CAPACITY];
    logic        [CAPACITY-1:0]      cell_le;
    logic        [CAPACITY-1:0]      first_hit;
    logic        [CAPACITY:0]        found;

    // Entry picked by a remove
    logic        [KEY_BITS-1:0]      rem_key;
    logic signed [SEVERITY_BITS-1:0] rem_sev;

    logic out_free;
    logic in_accept;
    logic is_full;

    assign req     = s_axis_tuser;
    assign in_sev  = s_axis_tdata[79:64];
    assign new_key = s_axis_tdata[KEY_BITS-1:0];
    assign new_sev = SEVERITY_BITS'(in_sev);

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_full       = (r_count >= CNT_W'(CAPACITY));

    assign found[0] = 1'b0;

    // Build the row; the right neighbor of the last occupied cell wraps to
    // cell 0 so a view rotation closes the ring over the occupied cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign cell_ctl[i].op  = cell_op;
        assign cell_ctl[i].occ = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign left_key[i] = new_key;
            assign left_sev[i] = new_sev;
        end else begin : g_inner
            assign left_key[i] = cell_key[i-1];
            assign left_sev[i] = cell_sev[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_key[i] = cell_key[0];
            assign right_sev[i] = cell_sev[0];
        end else begin : g_body
            assign right_key[i] = (CNT_W'(i + 1) == r_count) ? cell_key[0] : cell_key[i+1];
            assign right_sev[i] = (CNT_W'(i + 1) == r_count) ? cell_sev[0] : cell_sev[i+1];
        end

        ssk_cell #(
            .KEY_BITS      (KEY_BITS),
            .SEVERITY_BITS (SEVERITY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[i]),
            .i_new_key   (new_key),
            .i_new_sev   (new_sev),
            .i_left_key  (left_key[i]),
            .i_left_sev  (left_sev[i]),
            .i_left_le   ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
            .i_right_key (right_key[i]),
            .i_right_sev (right_sev[i]),
            .i_found_in  (found[i]),
            .o_key       (cell_key[i]),
            .o_sev       (cell_sev[i]),
            .o_le        (cell_le[i]),
            .o_found     (found[i+1]),
            .o_first_hit (first_hit[i])
        );
    end

    // Pull out the entry of the first matching cell (one-hot select)
    always_comb begin
        rem_key = '0;
        rem_sev = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rem_key = rem_key | (cell_key[i] & {KEY_BITS{first_hit[i]}});
            rem_sev = rem_sev | (cell_sev[i] & {SEVERITY_BITS{first_hit[i]}});
        end
    end

    // Sequencer: decode the request, steer the row, fill the output register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        cell_op     = CELL_HOLD;
        load_out    = 1'b0;
        n_status    = STATUS_OK;
        n_ent_valid = 1'b0;
        n_ent_key   = '0;
        n_ent_sev   = '0;
        n_last      = 1'b1;

        if (r_state == ST_IDLE) begin
            if (in_accept) begin
                load_out = 1'b1;
                priority if (req == REQ_INSERT) begin
                    if (is_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        cell_op     = CELL_INSERT;
                        n_count     = r_count + 1'b1;
                        n_ent_valid = 1'b1;
                        n_ent_key   = KEY_W'(new_key);
                        n_ent_sev   = SEV_W'(new_sev);
                    end
                end else if (req == REQ_REMOVE) begin
                    if (found[CAPACITY]) begin
                        cell_op     = CELL_REMOVE;
                        n_count     = r_count - 1'b1;
                        n_ent_valid = 1'b1;
                        n_ent_key   = KEY_W'(rem_key);
                        n_ent_sev   = SEV_W'(rem_sev);
                    end else begin
                        n_status = STATUS_NOT_FOUND;
                    end
                end else begin
                    // View and the unused code: empty table answers at once
                    if (r_count != '0) begin
                        load_out = 1'b0;
                        n_state  = ST_VIEW;
                        n_left   = r_count;
                    end
                end
            end
        end else if (out_free) begin
            // Emit cell 0 and advance the ring by one
            load_out    = 1'b1;
            cell_op     = CELL_ROTATE;
            n_ent_valid = 1'b1;
            n_ent_key   = KEY_W'(cell_key[0]);
            n_ent_sev   = SEV_W'(cell_sev[0]);
            n_last      = (r_left == CNT_W'(1));
            n_left      = r_left - 1'b1;
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status    <= n_status;
            r_ent_valid <= n_ent_valid;
            r_ent_key   <= n_ent_key;
            r_ent_sev   <= n_ent_sev;
            r_ent_count <= COUNT_W'(n_count);
            r_last      <= n_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_ent_count, r_ent_sev, r_ent_key};
    assign m_axis_tuser  = {r_ent_valid, r_status};
    assign m_axis_tlast  = r_last;

endmodule

// ===== hdl/ssk_cell.sv =====
// ----------------------------------------------------------------------------
// ssk_cell
// One slot of the sorted table: holds a key and a severity, and takes a new
// entry, its left neighbor or its right neighbor as the chain moves.
// ----------------------------------------------------------------------------
module ssk_cell
    import ssk_pkg::*;
#(
    parameter int KEY_BITS      = 64,
    parameter int SEVERITY_BITS = 16
) (
    input  logic                            i_clk,
    input  t_cell_ctl                       i_ctl,
    input  logic        [KEY_BITS-1:0]      i_new_key,
    input  logic signed [SEVERITY_BITS-1:0] i_new_sev,
    input  logic        [KEY_BITS-1:0]      i_left_key,
    input  logic signed [SEVERITY_BITS-1:0] i_left_sev,
    input  logic                            i_left_le,
    input  logic        [KEY_BITS-1:0]      i_right_key,
    input  logic signed [SEVERITY_BITS-1:0] i_right_sev,
    input  logic                            i_found_in,
    output logic        [KEY_BITS-1:0]      o_key,
    output logic signed [SEVERITY_BITS-1:0] o_sev,
    output logic                            o_le,
    output logic                            o_found,
    output logic                            o_first_hit
);

    logic        [KEY_BITS-1:0]      r_key;
    logic signed [SEVERITY_BITS-1:0] r_sev;
    logic                            hit;

    // Entry stays in front of a new one of equal or higher severity
    assign o_le        = i_ctl.occ && (r_sev <= i_new_sev);
    assign hit         = i_ctl.occ && (r_key == i_new_key);
    assign o_found     = i_found_in | hit;
    assign o_first_hit = hit & ~i_found_in;
    assign o_key       = r_key;
    assign o_sev       = r_sev;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        r_key <= i_new_key;
                        r_sev <= i_new_sev;
                    end else begin
                        r_key <= i_left_key;
                        r_sev <= i_left_sev;
                    end
                end
            end
            CELL_REMOVE: begin
                if (o_found) begin
                    r_key <= i_right_key;
                    r_sev <= i_right_sev;
                end
            end
            CELL_ROTATE: begin
                r_key <= i_right_key;
                r_sev <= i_right_sev;
            end
            CELL_HOLD: begin
            end
        endcase
    end

endmodule

// ===== hdl/ssk_checker.sv =====
// ----------------------------------------------------------------------------
// ssk_checker
// Port-level checks for the severity-sorted keyed table, bound to the top.
// ----------------------------------------------------------------------------
module ssk_checker
    import ssk_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [79:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A request is taken only when the output slot can take its result
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("request taken with output slot blocked");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A result without an entry carries zero key and severity
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[79:0] == 80'd0)
        else $error("empty result carries entry data");

    // A refused request is a single result without an entry
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_OK) |->
            m_axis_tlast && !m_axis_tuser[2])
        else $error("refused request with entry or without last");

endmodule

bind severity_sorted_keyed_table ssk_checker u_ssk_checker (.*);

// ===== tb/severity_table_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// severity_table_scoreboard_pkg
// Predicts and checks the results of the severity-sorted keyed table.
// ----------------------------------------------------------------------------
package severity_table_scoreboard_pkg;
    import ssk_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               entry_valid;
        logic [KEY_W-1:0]   entry_key;
        logic [SEV_W-1:0]   entry_severity;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_table_result;

    class severity_table_scoreboard;
        // Shadow copy of the table, lowest severity first
        logic [KEY_W-1:0]        held_keys [TABLE_DEPTH];
        logic signed [SEV_W-1:0] held_sevs [TABLE_DEPTH];
        int                      held_count;

        t_table_result awaited_results [$];

        int mismatches;
        int results_seen;
        int inserts_stored;
        int inserts_refused;
        int removes_hit;
        int removes_missed;
        int views_done;
        int peak_fill;

        function new();
            held_count      = 0;
            mismatches      = 0;
            results_seen    = 0;
            inserts_stored  = 0;
            inserts_refused = 0;
            removes_hit     = 0;
            removes_missed  = 0;
            views_done      = 0;
            peak_fill       = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void queue_result(logic [STAT_W-1:0] status, logic valid,
                                   logic [KEY_W-1:0] key, logic [SEV_W-1:0] sev,
                                   logic last);
            t_table_result r;
            r.status         = status;
            r.entry_valid    = valid;
            r.entry_key      = key;
            r.entry_severity = sev;
            r.entry_count    = COUNT_W'(held_count);
            r.last           = last;
            awaited_results.push_back(r);
        endfunction

        // Apply one accepted request to the shadow table and queue its results
        function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                   logic signed [SEV_W-1:0] sev);
            int                      pos;
            int                      i;
            logic [KEY_W-1:0]        gone_key;
            logic signed [SEV_W-1:0] gone_sev;
            case (req)
                REQ_INSERT: begin
                    if (held_count >= TABLE_DEPTH) begin
                        inserts_refused++;
                        queue_result(STATUS_FULL, 1'b0, '0, '0, 1'b1);
                    end else begin
                        // stable order: skip past every equal severity
                        pos = 0;
                        while (pos < held_count && held_sevs[pos] <= sev)
                            pos++;
                        for (i = held_count; i > pos; i--) begin
                            held_keys[i] = held_keys[i-1];
                            held_sevs[i] = held_sevs[i-1];
                        end
                        held_keys[pos] = key;
                        held_sevs[pos] = sev;
                        held_count++;
                        if (held_count > peak_fill)
                            peak_fill = held_count;
                        inserts_stored++;
                        queue_result(STATUS_OK, 1'b1, key, sev, 1'b1);
                    end
                end
                REQ_REMOVE: begin
                    pos = 0;
                    while (pos < held_count && held_keys[pos] != key)
                        pos++;
                    if (pos >= held_count) begin
                        removes_missed++;
                        queue_result(STATUS_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                    end else begin
                        gone_key = held_keys[pos];
                        gone_sev = held_sevs[pos];
                        for (i = pos; i + 1 < held_count; i++) begin
                            held_keys[i] = held_keys[i+1];
                            held_sevs[i] = held_sevs[i+1];
                        end
                        held_count--;
                        removes_hit++;
                        queue_result(STATUS_OK, 1'b1, gone_key, gone_sev, 1'b1);
                    end
                end
                default: begin
                    views_done++;
                    if (held_count == 0)
                        queue_result(STATUS_OK, 1'b0, '0, '0, 1'b1);
                    else
                        for (i = 0; i < held_count; i++)
                            queue_result(STATUS_OK, 1'b1, held_keys[i], held_sevs[i],
                                         i + 1 == held_count);
                end
            endcase
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: unexpected result ",
                              "st=%0d v=%0d key=%h sev=%h cnt=%0d last=%0d"},
                             got.status, got.entry_valid, got.entry_key,
                             got.entry_severity, got.entry_count, got.last);
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.entry_valid !== want.entry_valid ||
                got.entry_key !== want.entry_key ||
                got.entry_severity !== want.entry_severity ||
                got.entry_count !== want.entry_count || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"ERROR: result %0d expected ",
                              "st=%0d v=%0d key=%h sev=%h cnt=%0d last=%0d"},
                             results_seen, want.status, want.entry_valid,
                             want.entry_key, want.entry_severity,
                             want.entry_count, want.last);
                    $display({"       actual            ",
                              "st=%0d v=%0d key=%h sev=%h cnt=%0d last=%0d"},
                             got.status, got.entry_valid, got.entry_key,
                             got.entry_severity, got.entry_count, got.last);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/severity_sorted_keyed_table_test.sv =====
// ----------------------------------------------------------------------------
// severity_sorted_keyed_table_test
// Self-checking regression for the severity-sorted keyed table.
// ----------------------------------------------------------------------------
// Drives insert, remove and view requests over the request stream and checks
// every result transaction against a shadow table kept by a scoreboard. A
// directed opening fills the table to capacity with extreme keys and
// severities, then random traffic runs in three idling phases, one of them
// with a long consumer hold-off that backs the block up.
// ----------------------------------------------------------------------------
module severity_sorted_keyed_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssk_pkg::*;
    import severity_table_scoreboard_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int KEY_POOL_SIZE   = 24;
    localparam int PHASE_ITEMS     = 115;

    // Spare selector, which the block treats as a view
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;    // key[63:0], severity[79:64]
    logic [1:0]  s_axis_tuser = '0;    // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;         // entry_key[63:0], entry_severity[79:64],
                                       // entry_count[84:80], zero[87:85]
    logic [2:0]  m_axis_tuser;         // status[1:0], entry_valid[2]
    logic        m_axis_tlast;

    severity_table_scoreboard sb = new();

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_off_request = 1'b0;
    logic hold_off_done = 1'b0;
    int   requests_accepted = 0;

    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    severity_sorted_keyed_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample both streams at the edge: check results first, then record the
    // request, since a result never comes back in the cycle of its request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result('{status:         m_axis_tuser[1:0],
                                  entry_valid:    m_axis_tuser[2],
                                  entry_key:      m_axis_tdata[63:0],
                                  entry_severity: m_axis_tdata[79:64],
                                  entry_count:    m_axis_tdata[84:80],
                                  last:           m_axis_tlast});
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[79:64]);
                requests_accepted++;
            end
        end
    end

    // Consumer: random ready, plus one long hold-off when the stimulus asks
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_request && !hold_off_done) begin
                // hold ready low so the output and then the input back up
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request and hold it until the transaction completes. Valid
    // stays high into the next request unless an idle gap is drawn.
    task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                logic [SEV_W-1:0] sev);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {sev, key};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [SEV_W-1:0] pick_severity();
        int near;
        near = $urandom_range(8);
        case ($urandom_range(3))
            0: return SEV_W'($urandom);
            1: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7fff;
                   2: return 16'h0000;
                   default: return 16'hffff;
               endcase
            // cluster around zero so equal severities pile up
            default: return SEV_W'(near - 4);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit prefer_held);
        if (prefer_held && sb.held_count > 0 && $urandom_range(99) < 60)
            return sb.held_keys[$urandom_range(sb.held_count - 1)];
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // Random traffic in stretches that lean toward filling, draining or
    // neither, so the table swings between empty and full.
    task automatic run_random(int count);
        int               mode;
        int               roll;
        logic [REQ_W-1:0] req;
        for (int n = 0; n < count; n++) begin
            if (n % 31 == 0)
                mode = $urandom_range(2);
            roll = $urandom_range(99);
            case (mode)
                0:       req = (roll < 70) ? REQ_INSERT : (roll < 85) ? REQ_REMOVE : REQ_VIEW;
                1:       req = (roll < 20) ? REQ_INSERT : (roll < 85) ? REQ_REMOVE : REQ_VIEW;
                default: req = (roll < 42) ? REQ_INSERT : (roll < 80) ? REQ_REMOVE : REQ_VIEW;
            endcase
            // occasionally use the spare selector, which acts as a view
            if (req == REQ_VIEW && $urandom_range(3) == 0)
                req = REQ_SPARE;
            send_request(req, pick_key(req == REQ_REMOVE), pick_severity());
        end
    endtask

    initial begin
        int guard;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < KEY_POOL_SIZE; k++)
            key_pool[k] = {$urandom, $urandom};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, then fill to capacity with extremes
        send_request(REQ_VIEW,   '0, '0);
        send_request(REQ_SPARE,  '1, '1);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_INSERT, '1, 16'h7fff);
        send_request(REQ_INSERT, '0, 16'h8000);
        send_request(REQ_INSERT, 64'h0000_0000_0000_00a1, 16'h0000);
        send_request(REQ_INSERT, 64'h0000_0000_0000_00b2, 16'h0000);
        // same key twice: remove must take the first in table order
        send_request(REQ_INSERT, 64'h0000_0000_0000_00a1, 16'h0000);
        send_request(REQ_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 16'hffff);
        send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 16'h0001);
        send_request(REQ_INSERT, 64'h8000_0000_0000_0001, 16'h8000);
        send_request(REQ_INSERT, 64'h0123_4567_89ab_cdef, 16'h7fff);
        send_request(REQ_INSERT, 64'hfedc_ba98_7654_3210, 16'h4000);
        send_request(REQ_INSERT, 64'h0f0f_0f0f_0f0f_0f0f, 16'hc000);
        send_request(REQ_INSERT, 64'hf0f0_f0f0_f0f0_f0f0, 16'h0000);
        send_request(REQ_INSERT, 64'h7fff_ffff_ffff_fffe, 16'h0001);
        send_request(REQ_INSERT, 64'hdead_0000_beef_0000, 16'hffff);
        send_request(REQ_INSERT, 64'h0000_0001_0000_0000, 16'h8001);
        send_request(REQ_INSERT, 64'h1111_2222_3333_4444, 16'h7ffe);
        send_request(REQ_INSERT, 64'h9999_9999_9999_9999, 16'h1234);
        send_request(REQ_VIEW,   '0, '0);
        send_request(REQ_REMOVE, 64'h0000_0000_0000_00a1, '0);
        send_request(REQ_REMOVE, 64'h0000_0000_0000_0bad, '0);
        send_request(REQ_SPARE,  '0, '0);

        // Phase one: sender idles lightly, consumer heavily
        tx_idle_pct = 21;
        rx_idle_pct = 57;
        run_random(PHASE_ITEMS);

        // Phase two: swap the idling, and stall the consumer for a long stretch
        tx_idle_pct = 57;
        rx_idle_pct = 21;
        hold_off_request <= 1'b1;
        run_random(PHASE_ITEMS);

        // Phase three: full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;

        // Drain every awaited result, then idle a little for stragglers
        guard = 0;
        while (sb.outstanding() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $display("ERROR: %0d results never arrived", sb.outstanding());
            sb.mismatches++;
        end

        $display("Covered %0d requests and %0d results: %0d stored, %0d refused full,",
                 requests_accepted, sb.results_seen, sb.inserts_stored, sb.inserts_refused);
        $display("%0d removed, %0d not found, %0d views, peak fill %0d, %0d mismatches",
                 sb.removes_hit, sb.removes_missed, sb.views_done, sb.peak_fill,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("severity_sorted_keyed_table regression: pass");
        else
            $display("severity_sorted_keyed_table regression: fail");
        $finish;
    end

    // Watchdog: a correct run needs far less than this
    initial begin
        #3000000;
        $display("ERROR: watchdog expired");
        $display("severity_sorted_keyed_table regression: fail");
        $finish;
    end

endmodule
